// ===== rtl/cbpw_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpw_pkg: shared types and constants of the cubic b-spline path walker
// command codes, curve modes, q24 coefficients and the weight term program
// ----------------------------------------------------------------------------
package cbpw_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// end-condition modes
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_RAMP  = 3'd2;
	localparam logic [2:0] MODE_MID   = 3'd3;
	localparam logic [2:0] MODE_TAIL  = 3'd4;
	localparam logic [2:0] MODE_FINAL = 3'd5;

	// q24 coefficients, rounded to nearest
	localparam logic signed [27:0] C_ONE   = 28'sd16777216;
	localparam logic signed [27:0] C_7_4   = 28'sd29360128;
	localparam logic signed [27:0] C_9_2   = 28'sd75497472;
	localparam logic signed [27:0] C_3     = 28'sd50331648;
	localparam logic signed [27:0] C_11_12 = 28'sd15379115;
	localparam logic signed [27:0] C_3_2   = 28'sd25165824;
	localparam logic signed [27:0] C_1_6   = 28'sd2796203;
	localparam logic signed [27:0] C_1_4   = 28'sd4194304;
	localparam logic signed [27:0] C_7_12  = 28'sd9786709;
	localparam logic signed [27:0] C_5_4   = 28'sd20971520;
	localparam logic signed [27:0] C_1_2   = 28'sd8388608;
	localparam logic signed [27:0] C_2_3   = 28'sd11184811;

	// phase increment round(t * 2^24 / 1000) = t*16777 + (t*216 + 500) / 1000
	localparam int DIV_Q   = 16777;
	localparam int DIV_R   = 216;
	localparam int DIV_RND = 500;
	localparam int RECIP   = 8589935;  // ceil(2^33 / 1000), exact for 23-bit values

	// operand selects of a weight term
	typedef logic [2:0] osel_t;
	localparam osel_t OP_P   = 3'd0;
	localparam osel_t OP_PP  = 3'd1;
	localparam osel_t OP_PPP = 3'd2;
	localparam osel_t OP_N   = 3'd3;
	localparam osel_t OP_NN  = 3'd4;
	localparam osel_t OP_NNN = 3'd5;

	// multiplier result destinations
	localparam logic [1:0] WB_NONE = 2'd0;
	localparam logic [1:0] WB_POW  = 2'd1;
	localparam logic [1:0] WB_WGT  = 2'd2;
	localparam logic [1:0] WB_ACC  = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [1:0]        wsel;
		osel_t             osel;
		logic              neg;
		logic signed [27:0] coef;
	} term_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] idx;
		logic       neg;
	} wb_t;

	function automatic term_t mk_term(input logic [1:0] wsel, input osel_t osel,
			input logic neg, input logic signed [27:0] coef);
		term_t t;
		t.valid = 1'b1;
		t.wsel  = wsel;
		t.osel  = osel;
		t.neg   = neg;
		t.coef  = coef;
		return t;
	endfunction

	// weight w = const + sum of +-((operand * coef) >> 24), one term a cycle
	function automatic term_t term_rom(input logic [2:0] mode, input logic [3:0] k);
		term_t t;
		t = '0;
		case (mode)
			MODE_START: begin
				case (k)
					4'd0: t = mk_term(2'd0, OP_NNN, 1'b0, C_ONE);
					4'd1: t = mk_term(2'd1, OP_PPP, 1'b0, C_7_4);
					4'd2: t = mk_term(2'd1, OP_PP,  1'b1, C_9_2);
					4'd3: t = mk_term(2'd1, OP_P,   1'b0, C_3);
					4'd4: t = mk_term(2'd2, OP_PPP, 1'b1, C_11_12);
					4'd5: t = mk_term(2'd2, OP_PP,  1'b0, C_3_2);
					4'd6: t = mk_term(2'd3, OP_PPP, 1'b0, C_1_6);
					default: t = '0;
				endcase
			end
			MODE_RAMP: begin
				case (k)
					4'd0: t = mk_term(2'd0, OP_NNN, 1'b0, C_1_4);
					4'd1: t = mk_term(2'd1, OP_PPP, 1'b0, C_7_12);
					4'd2: t = mk_term(2'd1, OP_PP,  1'b1, C_5_4);
					4'd3: t = mk_term(2'd1, OP_P,   1'b0, C_1_4);
					4'd4: t = mk_term(2'd2, OP_PPP, 1'b1, C_1_2);
					4'd5: t = mk_term(2'd2, OP_PP,  1'b0, C_1_2);
					4'd6: t = mk_term(2'd2, OP_P,   1'b0, C_1_2);
					4'd7: t = mk_term(2'd3, OP_PPP, 1'b0, C_1_6);
					default: t = '0;
				endcase
			end
			MODE_MID: begin
				case (k)
					4'd0: t = mk_term(2'd0, OP_NNN, 1'b0, C_1_6);
					4'd1: t = mk_term(2'd1, OP_PPP, 1'b0, C_1_2);
					4'd2: t = mk_term(2'd1, OP_PP,  1'b1, C_ONE);
					4'd3: t = mk_term(2'd2, OP_PPP, 1'b1, C_1_2);
					4'd4: t = mk_term(2'd2, OP_PP,  1'b0, C_1_2);
					4'd5: t = mk_term(2'd2, OP_P,   1'b0, C_1_2);
					4'd6: t = mk_term(2'd3, OP_PPP, 1'b0, C_1_6);
					default: t = '0;
				endcase
			end
			MODE_TAIL: begin
				case (k)
					4'd0: t = mk_term(2'd0, OP_NNN, 1'b0, C_1_6);
					4'd1: t = mk_term(2'd1, OP_NNN, 1'b1, C_1_2);
					4'd2: t = mk_term(2'd1, OP_NN,  1'b0, C_1_2);
					4'd3: t = mk_term(2'd1, OP_N,   1'b0, C_1_2);
					4'd4: t = mk_term(2'd2, OP_NNN, 1'b0, C_7_12);
					4'd5: t = mk_term(2'd2, OP_NN,  1'b1, C_5_4);
					4'd6: t = mk_term(2'd2, OP_N,   1'b0, C_1_4);
					4'd7: t = mk_term(2'd3, OP_PPP, 1'b0, C_1_4);
					default: t = '0;
				endcase
			end
			MODE_FINAL: begin
				case (k)
					4'd0: t = mk_term(2'd0, OP_NNN, 1'b0, C_1_6);
					4'd1: t = mk_term(2'd1, OP_NNN, 1'b1, C_11_12);
					4'd2: t = mk_term(2'd1, OP_NN,  1'b0, C_3_2);
					4'd3: t = mk_term(2'd2, OP_NNN, 1'b0, C_7_4);
					4'd4: t = mk_term(2'd2, OP_NN,  1'b1, C_9_2);
					4'd5: t = mk_term(2'd2, OP_N,   1'b0, C_3);
					4'd6: t = mk_term(2'd3, OP_PPP, 1'b0, C_ONE);
					default: t = '0;
				endcase
			end
			default: t = '0;
		endcase
		return t;
	endfunction

	// constant part of each weight
	function automatic logic signed [27:0] wconst(input logic [2:0] mode, input logic [1:0] w);
		logic signed [27:0] c;
		c = '0;
		case (mode)
			MODE_RAMP: begin
				if (w == 2'd1) c = C_7_12;
				if (w == 2'd2) c = C_1_6;
			end
			MODE_MID: begin
				if (w == 2'd1) c = C_2_3;
				if (w == 2'd2) c = C_1_6;
			end
			MODE_TAIL: begin
				if (w == 2'd1) c = C_1_6;
				if (w == 2'd2) c = C_7_12;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/cubic_bspline_path_walker.sv =====
// ----------------------------------------------------------------------------
// cubic_bspline_path_walker: walks a cubic b-spline path over a point table
// one shared 28x33 multiplier evaluates the weights and blends four points
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  s_*      | in  | tuser cmd; tdata point_index, pos_x/y/z, seg_time
//  m_*      | out | tdata out_x/y/z; tuser finished, overrun
//
// a load or start transaction is taken in the idle state, which it keeps;
// a step runs from its accept through the powers, the weight terms (7 or 8
// terms, one a cycle, and a further pass for the last to land), four table
// reads with three products each, and the finish and output states. an
// overrun step goes from its accept to the output state. the point table is
// not cleared at reset. a finished result waits in the output register while
// input is taken; a step stalls at its end until that register is free.
//
module cubic_bspline_path_walker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,   // point_index, pos_x, pos_y, pos_z, seg_time
	input  logic [1:0]   s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // out_x, out_y, out_z
	output logic [1:0]   m_tuser    // finished, overrun
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = (AW > 6) ? AW : 6;   // segment index also holds any start index
	localparam int EW = 111;                 // x, y, z, time

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POW  = 3'd1;
	localparam logic [2:0] S_TERM = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [24:0] ONE25 = 25'h1000000;

	// input fields
	logic [1:0]  cmd;
	logic [5:0]  point_index;
	logic [31:0] pos_x, pos_y, pos_z;
	logic [14:0] seg_time;
	logic        accept;

	assign cmd         = s_tuser;
	assign point_index = s_tdata[5:0];
	assign pos_x       = s_tdata[37:6];
	assign pos_y       = s_tdata[69:38];
	assign pos_z       = s_tdata[101:70];
	assign seg_time    = s_tdata[116:102];
	assign accept      = s_tvalid && s_tready;

	// control state
	logic [2:0]    state_q;
	logic [3:0]    cnt_q;
	logic [1:0]    j_q;
	logic [SW-1:0] seg_q;
	logic [31:0]   phase_q;
	logic [2:0]    mode_q;
	logic          ovr_q;
	logic          m_tvalid_q;
	cbpw_pkg::wb_t wb_s1;

	// datapath registers
	logic [EW-1:0]        mem [TABLE_DEPTH];
	logic [EW-1:0]        rd_q;
	logic signed [60:0]   prod_s1;
	logic [24:0]          pw_q [4];     // pp, nn, ppp, nnn
	logic signed [27:0]   wgt_q [4];
	logic signed [63:0]   acc_q [3];
	logic [22:0]          r_q;
	logic [29:0]          tq_q;
	logic [31:0]          inc_q;
	logic [14:0]          time3_q;
	logic [95:0]          m_tdata_q;
	logic [1:0]           m_tuser_q;

	// phase argument
	logic [24:0] p, n;
	assign p = (phase_q > 32'(ONE25)) ? ONE25 : phase_q[24:0];
	assign n = ONE25 - p;

	// address and range checks
	logic [SW-1:0] idx_w, seg_sum;
	logic [AW-1:0] rd_addr;
	logic          idx_ok, ovr_now;
	assign idx_w   = SW'(point_index);
	assign idx_ok  = (SW+1)'(point_index) < (SW+1)'(TABLE_DEPTH);
	assign ovr_now = ({1'b0, seg_q} + (SW+1)'(3)) >= (SW+1)'(TABLE_DEPTH);
	assign seg_sum = seg_q + SW'(j_q);
	assign rd_addr = seg_sum[AW-1:0];

	// shared multiplier operand selection
	cbpw_pkg::term_t    cur_term;
	logic [24:0]        term_opnd;
	logic signed [27:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [60:0] mul_p;
	cbpw_pkg::wb_t      mul_wb;
	logic [31:0]        coord;

	assign cur_term = cbpw_pkg::term_rom(mode_q, cnt_q);

	always_comb begin
		case (cur_term.osel)
			cbpw_pkg::OP_P:   term_opnd = p;
			cbpw_pkg::OP_PP:  term_opnd = pw_q[0];
			cbpw_pkg::OP_PPP: term_opnd = pw_q[2];
			cbpw_pkg::OP_N:   term_opnd = n;
			cbpw_pkg::OP_NN:  term_opnd = pw_q[1];
			cbpw_pkg::OP_NNN: term_opnd = pw_q[3];
			default:          term_opnd = '0;
		endcase
	end

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    coord = rd_q[31:0];
			2'd1:    coord = rd_q[63:32];
			default: coord = rd_q[95:64];
		endcase
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_wb = '{kind: cbpw_pkg::WB_NONE, idx: 2'd0, neg: 1'b0};
		case (state_q)
			S_POW: begin
				if (!cnt_q[2]) begin
					mul_wb = '{kind: cbpw_pkg::WB_POW, idx: cnt_q[1:0], neg: 1'b0};
					case (cnt_q[1:0])
						2'd0: begin mul_a = 28'(p);       mul_b = 33'(p); end
						2'd1: begin mul_a = 28'(n);       mul_b = 33'(n); end
						2'd2: begin mul_a = 28'(pw_q[0]); mul_b = 33'(p); end
						default: begin mul_a = 28'(pw_q[1]); mul_b = 33'(n); end
					endcase
				end
			end
			S_TERM: begin
				if (cur_term.valid) begin
					mul_a  = cur_term.coef;
					mul_b  = 33'(term_opnd);
					mul_wb = '{kind: cbpw_pkg::WB_WGT, idx: cur_term.wsel, neg: cur_term.neg};
				end
			end
			S_MUL: begin
				mul_a  = wgt_q[j_q];
				mul_b  = 33'(signed'(coord));
				mul_wb = '{kind: cbpw_pkg::WB_ACC, idx: cnt_q[1:0], neg: 1'b0};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// phase increment from the segment time, reciprocal multiply
	logic [46:0] rm;
	assign rm = 47'(r_q) * 47'(cbpw_pkg::RECIP);

	// rounding of a q40 sum to saturated s15.16
	function automatic logic [31:0] round_sat(input logic signed [63:0] acc);
		logic signed [63:0] t;
		logic signed [39:0] q;
		logic [31:0]        r;
		t = acc + 64'sd8388608;
		q = 40'(t >>> 24);
		if (q > 40'sd2147483647)       r = 32'h7FFFFFFF;
		else if (q < -40'sd2147483648) r = 32'h80000000;
		else                           r = q[31:0];
		return r;
	endfunction

	// end of step: phase advance and segment rollover
	logic        out_free;
	logic [32:0] sum33;
	logic [31:0] ph_sat;
	logic        roll;
	assign out_free = !m_tvalid_q || m_tready;
	assign sum33    = {1'b0, phase_q} + {1'b0, inc_q};
	assign ph_sat   = sum33[32] ? 32'hFFFFFFFF : sum33[31:0];
	assign roll     = ph_sat >= 32'(ONE25);

	// table memory, one write port for loads and one registered read port
	always_ff @(posedge clk) begin
		if (accept && cmd == cbpw_pkg::CMD_LOAD && idx_ok) begin
			mem[idx_w[AW-1:0]] <= {seg_time, pos_z, pos_y, pos_x};
		end
		if (state_q == S_RD) begin
			rd_q <= mem[rd_addr];
		end
	end

	// datapath: product register and its write-back
	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;
		inc_q   <= {2'b00, tq_q} + 32'(rm[46:33]);
		if (accept && cmd == cbpw_pkg::CMD_STEP) begin
			for (int w = 0; w < 4; w++) begin
				wgt_q[w] <= cbpw_pkg::wconst(mode_q, 2'(w));
			end
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			case (wb_s1.kind)
				cbpw_pkg::WB_POW: pw_q[wb_s1.idx] <= prod_s1[48:24];
				cbpw_pkg::WB_WGT: begin
					if (wb_s1.neg) wgt_q[wb_s1.idx] <= wgt_q[wb_s1.idx] - prod_s1[51:24];
					else           wgt_q[wb_s1.idx] <= wgt_q[wb_s1.idx] + prod_s1[51:24];
				end
				cbpw_pkg::WB_ACC: begin
					if (wb_s1.idx != 2'd3) begin
						acc_q[wb_s1.idx] <= acc_q[wb_s1.idx] + 64'(prod_s1);
					end
				end
				default: ;
			endcase
		end
		// segment time of the first entry sets the phase step, the last one the mode
		if (state_q == S_MUL && cnt_q == 4'd0 && j_q == 2'd0) begin
			tq_q <= 30'(rd_q[110:96] * cbpw_pkg::DIV_Q);
			r_q  <= 23'(rd_q[110:96] * cbpw_pkg::DIV_R + cbpw_pkg::DIV_RND);
		end
		if (state_q == S_MUL && cnt_q == 4'd0 && j_q == 2'd3) begin
			time3_q <= rd_q[110:96];
		end
		if (state_q == S_OUT && out_free) begin
			if (ovr_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 2'b10;
			end else begin
				m_tdata_q <= {round_sat(acc_q[2]), round_sat(acc_q[1]), round_sat(acc_q[0])};
				m_tuser_q <= {1'b0, roll && mode_q == cbpw_pkg::MODE_FINAL};
			end
		end
	end

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			j_q        <= '0;
			seg_q      <= '0;
			phase_q    <= '0;
			mode_q     <= cbpw_pkg::MODE_START;
			ovr_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			wb_s1      <= '{kind: cbpw_pkg::WB_NONE, idx: 2'd0, neg: 1'b0};
		end else begin
			wb_s1 <= mul_wb;
			// a finished step loads the output register, else a taken result leaves it
			if (state_q == S_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							cbpw_pkg::CMD_START: begin
								seg_q   <= idx_w;
								phase_q <= '0;
								mode_q  <= cbpw_pkg::MODE_START;
							end
							cbpw_pkg::CMD_STEP: begin
								ovr_q   <= ovr_now;
								cnt_q   <= '0;
								state_q <= ovr_now ? S_OUT : S_POW;
							end
							default: ;
						endcase
					end
				end
				S_POW: begin
					// four powers, then an idle count while nnn lands
					if (cnt_q == 4'd4) begin
						cnt_q   <= '0;
						state_q <= S_TERM;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_TERM: begin
					if (cur_term.valid) begin
						cnt_q <= cnt_q + 4'd1;
					end else begin
						j_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == 4'd2) begin
						if (j_q == 2'd3) begin
							state_q <= S_FIN;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_RD;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (!ovr_q && roll) begin
							phase_q <= ph_sat - 32'(ONE25);
							seg_q   <= seg_q + SW'(1);
							if (mode_q == cbpw_pkg::MODE_MID) begin
								if (time3_q == '0) mode_q <= cbpw_pkg::MODE_TAIL;
							end else if (mode_q != cbpw_pkg::MODE_FINAL) begin
								mode_q <= mode_q + 3'd1;
							end
						end else if (!ovr_q) begin
							phase_q <= ph_sat;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// an overrun transaction carries no position and no finish flag
	a_ovr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
		else $error("overrun result with nonzero payload");

	// the walk mode never leaves the five end conditions
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 3'd0 && mode_q <= cbpw_pkg::MODE_FINAL)
		else $error("curve mode out of range");

	// a finished step is presented once the output register is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> m_tvalid && state_q == S_IDLE)
		else $error("finished step not presented");

	// accumulator write-back follows a blend multiply
	a_acc_wb: assert property (@(posedge clk) disable iff (!arst_n)
		wb_s1.kind == cbpw_pkg::WB_ACC |-> $past(state_q) == S_MUL)
		else $error("stray accumulator write-back");
`endif

endmodule
